/* rtl/lzrle_pkg.sv */
// Shared types and constants of the LZ/RLE/literal decompressor.
package lzrle_pkg;

  localparam int HIST_AW   = 12;
  localparam int LANES     = 8;
  localparam int CNT_W     = 4;
  localparam int RUN_W     = 9;
  localparam int TOTAL_W   = 32;

  localparam logic [7:0] LZ_EXT_BIAS  = 8'h0A;
  localparam logic [7:0] EXT_BIAS     = 8'h40;
  localparam logic [7:0] LZ_FLAG      = 8'h80;
  localparam logic [7:0] RLE_FLAG     = 8'h40;
  localparam logic [3:0] DIST_HI_MASK = 4'hF;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    PH_OPCODE  = 3'd0,
    PH_LZ_LOW  = 3'd1,
    PH_LZ_EXT  = 3'd2,
    PH_RLE_EXT = 3'd3,
    PH_LIT_EXT = 3'd4,
    PH_LITERAL = 3'd5
  } phase_t;

  typedef struct packed {
    logic accept;
    logic rd_issue;
    logic rd_data;
  } ctl_cmd_t;

  typedef struct packed {
    logic tot_ok;
    logic run_go;
    logic lit_go;
    logic lanes_full;
    logic lanes_empty;
    logic last_byte;
  } dp_status_t;

endpackage

/* rtl/lzrle_ctrl.sv */
// Sequencer that steps the decoder through accept, history read and flush.
module lzrle_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  lzrle_pkg::dp_status_t st,
  output lzrle_pkg::ctl_cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RD    = 4'b0010,
    S_DAT   = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    s_tready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.rd_issue = 1'b0;
    cmd.rd_data  = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready   = st.tot_ok;
        cmd.accept = st.tot_ok && s_tvalid;
        if (cmd.accept) begin
          if (st.run_go) begin
            state_next = S_RD;
          end else if (st.lit_go) begin
            state_next = S_FLUSH;
          end
        end
      end
      S_RD: begin
        // Wait until the lane buffer is no longer full before fetching another byte.
        if (!st.lanes_full) begin
          cmd.rd_issue = 1'b1;
          state_next   = S_DAT;
        end
      end
      S_DAT: begin
        cmd.rd_data = 1'b1;
        state_next  = st.last_byte ? S_FLUSH : S_RD;
      end
      S_FLUSH: begin
        if (st.lanes_empty) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* rtl/lzrle_datapath.sv */
// Parser registers, history memory, lane buffer and output register.
module lzrle_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [15:0]           cfg_wdata,
  input  logic [7:0]            in_byte,
  input  logic                  frame_start,
  input  lzrle_pkg::ctl_cmd_t   cmd,
  output lzrle_pkg::dp_status_t st,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [71:0]           m_tdata,
  output logic                  m_tlast,
  output logic                  m_tuser
);

  localparam int AW = lzrle_pkg::HIST_AW;
  localparam int RW = lzrle_pkg::RUN_W;
  localparam int TW = lzrle_pkg::TOTAL_W;
  localparam int LN = lzrle_pkg::LANES;
  localparam int CW = lzrle_pkg::CNT_W;

  logic [15:0] image_width, image_height;
  logic [TW-1:0] total;
  logic tot_ok;

  lzrle_pkg::phase_t phase, phase_next;
  logic [2:0]    pend_len, pend_len_next;
  logic [AW-1:0] copy_dist, copy_dist_next;
  logic [RW-1:0] lit_left, lit_left_next;
  logic [TW-1:0] bw;
  logic [RW-1:0] run_left;
  logic [AW-1:0] run_dist;

  logic [7:0] hist [2**AW];
  logic [7:0] rdata;
  logic       rd_valid;
  logic       wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  logic [7:0]  lanes [LN];
  logic [CW-1:0] lane_cnt;

  // Values seen after an optional frame clear.
  lzrle_pkg::phase_t e_phase;
  logic [2:0]    e_pl;
  logic [AW-1:0] e_cd;
  logic [RW-1:0] e_ll;
  logic [TW-1:0] e_bw;
  logic [TW-1:0] rem;
  logic          active;
  logic          run_go, lit_go;
  logic [RW-1:0] run_n, run_len, lit_n, lit_cl, ll_dec;
  logic [AW-1:0] run_d;
  logic [AW-1:0] rd_addr;
  logic [7:0]    dat_byte;
  logic          flush;
  logic [8*LN-1:0] lane_flat;

  function automatic logic [RW-1:0] clamp(input logic [RW-1:0] n, input logic [TW-1:0] r);
    return ({{(TW-RW){1'b0}}, n} > r) ? r[RW-1:0] : n;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= '0;
      image_height <= '0;
      tot_ok       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          lzrle_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_wdata;
          lzrle_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_wdata;
          default: ;
        endcase
      end
      tot_ok <= !cfg_we;
    end
  end

  always_ff @(posedge clk) begin
    total <= image_width * image_height;
  end

  always_comb begin
    e_phase = frame_start ? lzrle_pkg::PH_OPCODE : phase;
    e_pl    = frame_start ? 3'd0 : pend_len;
    e_cd    = frame_start ? '0 : copy_dist;
    e_ll    = frame_start ? '0 : lit_left;
    e_bw    = frame_start ? '0 : bw;
    active  = e_bw < total;
    rem     = total - e_bw;

    phase_next     = e_phase;
    pend_len_next  = e_pl;
    copy_dist_next = e_cd;
    lit_left_next  = e_ll;
    run_go = 1'b0;
    lit_go = 1'b0;
    run_n  = '0;
    run_d  = '0;
    lit_n  = '0;
    ll_dec = (e_ll != '0) ? e_ll - RW'(1) : e_ll;
    lit_cl = '0;

    if (active) begin
      case (e_phase)
        lzrle_pkg::PH_LZ_LOW: begin
          copy_dist_next = {e_cd[AW-1:8], in_byte};
          if (e_pl != 3'd0) begin
            run_go     = 1'b1;
            run_n      = RW'(e_pl) + RW'(2);
            run_d      = copy_dist_next;
            phase_next = lzrle_pkg::PH_OPCODE;
          end else begin
            phase_next = lzrle_pkg::PH_LZ_EXT;
          end
        end
        lzrle_pkg::PH_LZ_EXT: begin
          run_go     = 1'b1;
          run_n      = RW'(in_byte) + RW'(lzrle_pkg::LZ_EXT_BIAS);
          run_d      = e_cd;
          phase_next = lzrle_pkg::PH_OPCODE;
        end
        lzrle_pkg::PH_RLE_EXT: begin
          run_go     = 1'b1;
          run_n      = RW'(in_byte) + RW'(lzrle_pkg::EXT_BIAS) + RW'(1);
          phase_next = lzrle_pkg::PH_OPCODE;
        end
        lzrle_pkg::PH_LIT_EXT: begin
          lit_n         = RW'(in_byte) + RW'(lzrle_pkg::EXT_BIAS);
          lit_cl        = clamp(lit_n, rem);
          lit_left_next = lit_cl;
          phase_next    = (lit_cl != '0) ? lzrle_pkg::PH_LITERAL : lzrle_pkg::PH_OPCODE;
        end
        lzrle_pkg::PH_LITERAL: begin
          lit_go        = 1'b1;
          lit_left_next = ll_dec;
          if (ll_dec == '0 || rem == TW'(1)) begin
            lit_left_next = '0;
            phase_next    = lzrle_pkg::PH_OPCODE;
          end
        end
        default: begin
          phase_next = lzrle_pkg::PH_OPCODE;
          if ((in_byte & lzrle_pkg::LZ_FLAG) != 8'd0) begin
            copy_dist_next = {in_byte[3:0] & lzrle_pkg::DIST_HI_MASK, 8'd0};
            pend_len_next  = in_byte[6:4];
            phase_next     = lzrle_pkg::PH_LZ_LOW;
          end else if ((in_byte & lzrle_pkg::RLE_FLAG) != 8'd0) begin
            if (in_byte[5:0] != 6'd0) begin
              run_go = 1'b1;
              run_n  = RW'(in_byte[5:0]) + RW'(1);
            end else begin
              phase_next = lzrle_pkg::PH_RLE_EXT;
            end
          end else begin
            if (in_byte[5:0] != 6'd0) begin
              lit_n         = RW'(in_byte[5:0]);
              lit_cl        = clamp(lit_n, rem);
              lit_left_next = lit_cl;
              phase_next    = lzrle_pkg::PH_LITERAL;
            end else begin
              phase_next = lzrle_pkg::PH_LIT_EXT;
            end
          end
        end
      endcase
    end
    run_len = clamp(run_n, rem);
  end

  assign rd_addr  = bw[AW-1:0] - run_dist - AW'(1);
  assign dat_byte = rd_valid ? rdata : 8'd0;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = bw[AW-1:0];
    wr_data = dat_byte;
    if (cmd.accept && lit_go) begin
      wr_en   = 1'b1;
      wr_addr = e_bw[AW-1:0];
      wr_data = in_byte;
    end else if (cmd.rd_data) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist[wr_addr] <= wr_data;
    end
    if (cmd.rd_issue) begin
      rdata    <= hist[rd_addr];
      // Entries not yet written since the frame began read as zero.
      rd_valid <= (bw[TW-1:AW] != '0) || (rd_addr < bw[AW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= lzrle_pkg::PH_OPCODE;
      pend_len  <= '0;
      copy_dist <= '0;
      lit_left  <= '0;
      bw        <= '0;
      run_left  <= '0;
      run_dist  <= '0;
    end else if (cmd.accept) begin
      phase     <= phase_next;
      pend_len  <= pend_len_next;
      copy_dist <= copy_dist_next;
      lit_left  <= lit_left_next;
      bw        <= lit_go ? e_bw + TW'(1) : e_bw;
      run_left  <= run_go ? run_len : '0;
      run_dist  <= run_d;
    end else if (cmd.rd_data) begin
      bw       <= bw + TW'(1);
      run_left <= run_left - RW'(1);
    end
  end

  assign flush = ((lane_cnt == CW'(LN)) || (run_left == '0 && lane_cnt != '0))
                 && (!m_tvalid || m_tready);

  always_comb begin
    for (int i = 0; i < LN; i++) begin
      lane_flat[8*i +: 8] = lanes[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_cnt <= '0;
      for (int i = 0; i < LN; i++) begin
        lanes[i] <= 8'd0;
      end
    end else if (flush) begin
      lane_cnt <= '0;
      for (int i = 0; i < LN; i++) begin
        lanes[i] <= 8'd0;
      end
    end else if (cmd.accept && lit_go) begin
      lanes[0] <= in_byte;
      lane_cnt <= CW'(1);
    end else if (cmd.rd_data) begin
      lanes[lane_cnt[CW-2:0]] <= dat_byte;
      lane_cnt <= lane_cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (flush) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (flush) begin
      m_tdata <= {4'd0, lane_cnt, lane_flat};
      m_tlast <= run_left == '0;
      m_tuser <= bw >= total;
    end
  end

  assign st.tot_ok      = tot_ok;
  assign st.run_go      = run_go;
  assign st.lit_go      = lit_go;
  assign st.lanes_full  = lane_cnt == CW'(LN);
  assign st.lanes_empty = lane_cnt == '0;
  assign st.last_byte   = run_left == RW'(1);

endmodule

/* rtl/lz_rle_literal_decompressor.sv */
// Top level of the LZ/RLE/literal token stream decompressor.
//
// One compressed byte enters per request on the s_ channel (tdata = in_byte,
// tuser = frame_start, which clears the parser, the output count and the
// history before the byte is used). Decoded pixel bytes leave on the m_
// channel, up to eight per request, with tlast on the final request caused
// by an input byte and tuser set once width*height bytes have been written.
// The user must write the image size through the cfg_ port only while the
// block is idle; the block itself does not enforce it.
// A control byte leaves the sequencer in idle. A literal byte passes through
// the request, the move into the output register and the return to idle. An
// LZ copy or RLE repeat goes one byte at a time, with a wait while a full
// group of eight leaves the lane buffer: each byte is a read of the 4096-entry
// history memory with registered data, then a write back of that byte, which
// lets overlapping copies see bytes they just produced. A new request is taken
// once the run has left the lane buffer, even if its last result still waits.
// Reset clears the parser and the size registers; unwritten history entries
// are tracked by the output count, so no pass over the memory is needed.
// When the receiver stalls, the lane buffer fills and the run pauses until
// the output register is taken.
module lz_rle_literal_decompressor (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_byte
  input  logic        s_tuser,   // frame_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // out_b0..out_b7, byte_count, zero pad
  output logic        m_tlast,
  output logic        m_tuser    // image_done
);

  lzrle_pkg::ctl_cmd_t   cmd;
  lzrle_pkg::dp_status_t st;

  lzrle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  lzrle_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_byte     (s_tdata),
    .frame_start (s_tuser),
    .cmd         (cmd),
    .st          (st),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .m_tuser     (m_tuser)
  );

endmodule

/* rtl/lzrle_checker.sv */
// Port-level checks of the decompressor, bound to its top level.
module lzrle_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata,
  input logic        m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[67:64] != 4'd0) && (m_tdata[67:64] <= 4'd8))
    else $error("byte count out of range");

  a_partial: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[67:64] != 4'd8 |-> m_tlast)
    else $error("partial result not marked last");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind lz_rle_literal_decompressor lzrle_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

/* verif/tb_top.sv */
// Self-checking testbench for the LZ/RLE/literal token stream decompressor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 6000;
  localparam int SETTLE_CYCLES  = 80;
  localparam int MAX_RUN        = 320;

  // One compressed byte as offered on the input stream.
  typedef struct {
    logic [7:0] data;
    logic       start;
  } stream_byte_t;

  // One decoded result as expected on the output stream.
  typedef struct {
    logic [63:0] lanes;
    logic [3:0]  count;
    logic        last;
    logic        done;
  } pixel_group_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // in_byte
  logic        s_tuser = 1'b0;   // frame_start
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;          // out_b0..out_b7, byte_count, zero pad
  logic        m_tlast;
  logic        m_tuser;          // image_done

  lz_rle_literal_decompressor dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

  always #6 clk = ~clk;

  stream_byte_t pending_bytes[$];
  pixel_group_t expected_pixels[$];
  int  errors = 0;
  bit  quiet = 1'b0;        // when set, neither side idles
  int  rx_hold_requests = 0; // each increment asks the receiver for one long hold-off

  // Decoder state as the testbench tracks it.
  logic [15:0] img_w = 16'd0;
  logic [15:0] img_h = 16'd0;
  lzrle_pkg::phase_t phase = lzrle_pkg::PH_OPCODE;
  logic [8:0]  pend_len = 9'd0;
  logic [11:0] copy_dist = 12'd0;
  logic [8:0]  lit_left = 9'd0;
  logic [31:0] written = 32'd0;
  logic [7:0]  hist [4096];
  logic [11:0] hptr = 12'd0;
  logic [31:0] total;
  logic [7:0]  run_buf [MAX_RUN];
  int          run_n;

  initial foreach (hist[i]) hist[i] = 8'd0;

  function automatic logic [31:0] bytes_left();
    return (written >= total) ? 32'd0 : total - written;
  endfunction

  function automatic void put_pixel(input logic [7:0] b);
    if (written >= total || run_n >= MAX_RUN) return;
    hist[hptr] = b;
    hptr = hptr + 12'd1;
    run_buf[run_n] = b;
    run_n++;
    written++;
  endfunction

  function automatic logic [31:0] clamp(input logic [31:0] n);
    logic [31:0] r;
    r = bytes_left();
    return (n > r) ? r : n;
  endfunction

  // LZ copy: reads copy_dist+1 back, one byte at a time, so overlaps repeat.
  function automatic void lz_copy(input logic [31:0] n);
    logic [31:0] k;
    k = clamp(n);
    for (int i = 0; i < k; i++) put_pixel(hist[hptr - copy_dist - 12'd1]);
    phase = lzrle_pkg::PH_OPCODE;
  endfunction

  function automatic void rle_repeat(input logic [31:0] n);
    logic [31:0] k;
    logic [7:0]  b;
    b = hist[hptr - 12'd1];
    k = clamp(n);
    for (int i = 0; i < k; i++) put_pixel(b);
    phase = lzrle_pkg::PH_OPCODE;
  endfunction

  function automatic void open_literals(input logic [31:0] n);
    lit_left = 9'(clamp(n));
    phase = (lit_left != 0) ? lzrle_pkg::PH_LITERAL : lzrle_pkg::PH_OPCODE;
  endfunction

  // Decodes one accepted byte and queues the results it should cause.
  function automatic void decode_byte(input logic [7:0] b, input logic fs);
    logic [31:0] first;
    int nres, cnt, base;
    pixel_group_t g;
    if (fs) begin
      phase = lzrle_pkg::PH_OPCODE; pend_len = '0; copy_dist = '0; lit_left = '0;
      written = '0; hptr = '0;
      foreach (hist[i]) hist[i] = 8'd0;
    end
    total = img_w * img_h;
    run_n = 0;
    if (written >= total) return;
    first = written;
    case (phase)
      lzrle_pkg::PH_LZ_LOW: begin
        copy_dist = {copy_dist[11:8], b};
        if (pend_len != 0) lz_copy(pend_len + 2);
        else phase = lzrle_pkg::PH_LZ_EXT;
      end
      lzrle_pkg::PH_LZ_EXT:  lz_copy(b + lzrle_pkg::LZ_EXT_BIAS);
      lzrle_pkg::PH_RLE_EXT: rle_repeat(b + lzrle_pkg::EXT_BIAS + 1);
      lzrle_pkg::PH_LIT_EXT: open_literals(b + lzrle_pkg::EXT_BIAS);
      lzrle_pkg::PH_LITERAL: begin
        put_pixel(b);
        if (lit_left != 0) lit_left--;
        if (lit_left == 0 || written >= total) begin
          lit_left = '0;
          phase = lzrle_pkg::PH_OPCODE;
        end
      end
      default: begin
        phase = lzrle_pkg::PH_OPCODE;
        if (b & lzrle_pkg::LZ_FLAG) begin
          copy_dist = {b[3:0] & lzrle_pkg::DIST_HI_MASK, 8'd0};
          pend_len = 9'(b[6:4]);
          phase = lzrle_pkg::PH_LZ_LOW;
        end else if (b & lzrle_pkg::RLE_FLAG) begin
          if (b[5:0] != 0) rle_repeat(b[5:0] + 1);
          else phase = lzrle_pkg::PH_RLE_EXT;
        end else begin
          if (b[5:0] != 0) open_literals(b[5:0]);
          else phase = lzrle_pkg::PH_LIT_EXT;
        end
      end
    endcase
    nres = (run_n + lzrle_pkg::LANES - 1) / lzrle_pkg::LANES;
    for (int k = 0; k < nres; k++) begin
      base = k * lzrle_pkg::LANES;
      cnt = (run_n - base > lzrle_pkg::LANES) ? lzrle_pkg::LANES : run_n - base;
      g.lanes = '0;
      for (int j = 0; j < cnt; j++) g.lanes[j*8 +: 8] = run_buf[base + j];
      g.count = 4'(cnt);
      g.last = (k + 1 == nres);
      g.done = (first + base + cnt >= total);
      expected_pixels.push_back(g);
    end
  endfunction

  // Driver: offers queued bytes, with random gaps, and predicts on every acceptance.
  int tx_gap = 0;
  always @(posedge clk) begin
    stream_byte_t nb;
    logic hold_cur;
    if (!rst) begin
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tuser);
      hold_cur = s_tvalid && !s_tready;
      if (!hold_cur) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          s_tvalid <= 1'b0;
        end else if (pending_bytes.size() != 0 && !quiet && $urandom_range(0, 9) == 0) begin
          tx_gap <= $urandom_range(1, 14) - 1;
          s_tvalid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          nb = pending_bytes.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= nb.data;
          s_tuser <= nb.start;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest expectation.
  int rx_gap = 0;
  int rx_hold_seen = 0;
  always @(posedge clk) begin
    pixel_group_t g;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual data=%h last=%b done=%b",
                   $time, m_tdata, m_tlast, m_tuser);
          errors++;
        end else begin
          g = expected_pixels.pop_front();
          if (m_tdata[63:0] !== g.lanes) begin
            $display("%0t: pixel bytes mismatch: expected %h actual %h",
                     $time, g.lanes, m_tdata[63:0]);
            errors++;
          end
          if (m_tdata[67:64] !== g.count) begin
            $display("%0t: byte count mismatch: expected %0d actual %0d",
                     $time, g.count, m_tdata[67:64]);
            errors++;
          end
          if (m_tdata[71:68] !== 4'd0) begin
            $display("%0t: pad bits mismatch: expected 0 actual %h", $time, m_tdata[71:68]);
            errors++;
          end
          if (m_tlast !== g.last) begin
            $display("%0t: last mismatch: expected %b actual %b", $time, g.last, m_tlast);
            errors++;
          end
          if (m_tuser !== g.done) begin
            $display("%0t: image done mismatch: expected %b actual %b",
                     $time, g.done, m_tuser);
            errors++;
          end
        end
      end
      if (rx_hold_requests != rx_hold_seen) begin
        // A long hold-off lets the lane buffer fill and stall the input side.
        rx_hold_seen <= rx_hold_requests;
        rx_gap <= 400;
        m_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        rx_gap <= $urandom_range(1, 14) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no request moves for too long.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic fs = 1'b0);
    stream_byte_t x;
    x.data = b;
    x.start = fs;
    pending_bytes.push_back(x);
  endtask

  // Waits until the block has produced everything and had time to settle.
  // Sampling on the falling edge sees the driver's updates of the rising edge.
  task automatic drain();
    while (pending_bytes.size() != 0 || s_tvalid || expected_pixels.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == lzrle_pkg::REG_IMAGE_WIDTH) img_w = val;
    else img_h = val;
  endtask

  task automatic set_size(input logic [15:0] w, input logic [15:0] h);
    write_reg(lzrle_pkg::REG_IMAGE_WIDTH, w);
    write_reg(lzrle_pkg::REG_IMAGE_HEIGHT, h);
  endtask

  // Queues one token with random content; most are well formed, a few are noise.
  task automatic add_token(output int pushed);
    int kind, n;
    logic [11:0] d;
    logic fs;
    fs = ($urandom_range(0, 19) == 0);
    kind = $urandom_range(0, 9);
    pushed = 0;
    if (kind < 3) begin
      n = $urandom_range(0, 7);
      d = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 20));
      push_byte({1'b1, 3'(n), d[11:8]}, fs);
      push_byte(d[7:0]);
      pushed = 2;
      if (n == 0) begin
        push_byte(($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 30)));
        pushed++;
      end
    end else if (kind < 5) begin
      n = $urandom_range(0, 63);
      push_byte({2'b01, 6'(n)}, fs);
      pushed = 1;
      if (n == 0) begin
        push_byte(($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 10)));
        pushed++;
      end
    end else if (kind < 9) begin
      n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
      push_byte({2'b00, 6'(n)}, fs);
      pushed = 1;
      if (n == 0) begin
        n = $urandom_range(0, 6);
        push_byte(8'(n));
        n += 64;
        pushed++;
      end
      for (int i = 0; i < n; i++) push_byte(8'($urandom));
      pushed += n;
    end else begin
      push_byte(8'($urandom), 1'($urandom));
      pushed = 1;
    end
  endtask

  task automatic random_items(input int target);
    int got, p;
    got = 0;
    while (got < target) begin
      add_token(p);
      got += p;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Largest image: directed tokens, nothing gets clamped.
    set_size(16'hFFFF, 16'hFFFF);
    push_byte(8'h8F, 1'b1); push_byte(8'hFF);         // copy reaching before the frame
    push_byte(8'h03);                                 // its extended length
    push_byte(8'h03); push_byte(8'h00); push_byte(8'hFF); push_byte(8'h5A);
    push_byte(8'h42);                                 // short repeat
    push_byte(8'h40); push_byte(8'h05);               // extended repeat
    push_byte(8'h90); push_byte(8'h01);               // overlapping copy, distance 1
    push_byte(8'hF0); push_byte(8'h00);               // longest nibble length
    push_byte(8'h80); push_byte(8'h00); push_byte(8'hFF); // longest extended copy
    push_byte(8'h00); push_byte(8'h00);               // extended literal run
    for (int i = 0; i < 64; i++) push_byte(8'($urandom));
    push_byte(8'h7F);                                 // longest short repeat
    drain();

    // Tiny image: clamped runs and image complete. The receiver holds off
    // while the sender keeps offering, then the sender waits for everything.
    set_size(16'd16, 16'd4);
    rx_hold_requests++;
    push_byte(8'h40, 1'b1); push_byte(8'hFF);         // repeat past the end
    push_byte(8'h01); push_byte(8'h11);               // ignored once complete
    push_byte(8'h05, 1'b1); push_byte(8'hA1); push_byte(8'hB2);
    random_items(20);
    drain();
    random_items(15);
    drain();

    // Zero total: every byte is ignored.
    set_size(16'd0, 16'hFFFF);
    random_items(10);
    drain();

    // Registers changed mid-frame: one row of 300, then 7 by 3, then a zero total.
    set_size(16'd300, 16'd1);
    random_items(20);
    drain();
    set_size(16'd7, 16'd3);
    random_items(12);
    drain();
    set_size(16'hFFFF, 16'd0);
    random_items(5);
    drain();

    // Final stretch without any idling on a large image.
    set_size(16'hFFFF, 16'hFFFF);
    quiet = 1'b1;
    push_byte(8'h01, 1'b1); push_byte(8'hC3);
    random_items(25);
    drain();

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
